FILE: hdl/membership_heartbeat_table_core_assert.svh
// Assertion macros shared by the membership heartbeat table RTL.
`ifndef MEMBERSHIP_HEARTBEAT_TABLE_CORE_ASSERT_SVH
`define MEMBERSHIP_HEARTBEAT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define MHTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising clock edge outside reset.
`define MHTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/mhtc_pkg.sv
// Types and constants of the membership heartbeat table.
package mhtc_pkg;

   localparam int TABLE_DEPTH  = 16;
   localparam int IDX_W        = $clog2(TABLE_DEPTH);
   localparam int REMOVE_MAX   = 16;
   localparam int REM_W        = $clog2(REMOVE_MAX + 1);
   localparam int RSP_DEPTH    = REMOVE_MAX + 1;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH + 1);
   localparam int LIVE_W       = 5;
   localparam logic [31:0] OWN_HB_RESET = 32'd500;

   typedef enum logic [1:0] {
      CMD_JOIN_REQ = 2'd0,
      CMD_JOIN_REP = 2'd1,
      CMD_GOSSIP   = 2'd2,
      CMD_TICK     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_ADDED   = 3'd1,
      EV_REFRESH = 3'd2,
      EV_REMOVED = 3'd3,
      EV_FULL    = 3'd4,
      EV_TICK    = 3'd5
   } event_type;

   typedef enum logic [2:0] {
      CSR_SELF_ID    = 3'd0,
      CSR_SELF_PORT  = 3'd1,
      CSR_FAIL_TO    = 3'd2,
      CSR_REMOVE_TO  = 3'd3,
      CSR_INTRODUCER = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic [31:0] self_id;
      logic [15:0] self_port;
      logic [15:0] fail_to;
      logic [15:0] remove_to;
      logic        introducer;
   } cfg_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] id;
      logic [15:0] port;
      logic [31:0] hb;
      logic        self_match;
   } item_type;

   typedef struct packed {
      logic              push;
      logic              finish;
      event_type         kind;
      logic [31:0]       id;
      logic [15:0]       port;
      logic [LIVE_W-1:0] live;
   } rsp_wr_type;

endpackage

FILE: hdl/membership_heartbeat_table_core.sv
// Top level of the membership heartbeat table with its configuration registers.
//
// Usage: items enter through a queue-style port (push while full is low)
// and results leave through a queue-style port (a beat is taken when pop is
// high while empty is low). A two-entry input queue lets a sender push
// while the table engine is busy with an earlier item.
// Every item makes one result beat, except a tick inside the group, which makes
// one removal beat per expired entry and then a closing tick beat. The final
// beat of an item carries rsp_last_item, and all beats of one item carry the
// same rsp_live_count, taken after the whole item is done.
// An item that scans the table starts, walks all TABLE_DEPTH slots through the
// single scan port of the entry registers, decides and then settles the live
// count before its first beat shows; gossip or tick outside the group skips
// the scan.
// The engine starts the next item only after every beat of the previous one
// is taken, so a stalled receiver backs up into the input queue and full.
// Reset is synchronous; it empties both queues, clears the table and loads the
// register defaults. Configuration is written over the always-ready csr_
// channel; the user must do so while the block is idle, which is not enforced.
module membership_heartbeat_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_member_id,
   input  logic [15:0] req_member_port,
   input  logic [31:0] req_heartbeat,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_event_kind,
   output logic [31:0] rsp_out_member_id,
   output logic [15:0] rsp_out_member_port,
   output logic [4:0]  rsp_live_count,
   output logic        rsp_last_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mhtc_pkg::*;

   `include "membership_heartbeat_table_core_assert.svh"

   cfg_type    cfg_ff, cfg_in;
   item_type   item;
   logic       item_empty;
   logic       item_pop;
   logic       rsp_idle;
   rsp_wr_type rsp_wr;

   // The register port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SELF_ID:    cfg_in.self_id    = csr_wdata;
            CSR_SELF_PORT:  cfg_in.self_port  = csr_wdata[15:0];
            CSR_FAIL_TO:    cfg_in.fail_to    = csr_wdata[15:0];
            CSR_REMOVE_TO:  cfg_in.remove_to  = csr_wdata[15:0];
            CSR_INTRODUCER: cfg_in.introducer = csr_wdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.self_id    <= 32'd0;
         cfg_ff.self_port  <= 16'd0;
         cfg_ff.fail_to    <= 16'd5;
         cfg_ff.remove_to  <= 16'd20;
         cfg_ff.introducer <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accepts items and flags those that name this node.
   mhtc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .push        (push),
      .full        (full),
      .cmd         (req_cmd),
      .member_id   (req_member_id),
      .member_port (req_member_port),
      .heartbeat   (req_heartbeat),
      .empty       (item_empty),
      .pop         (item_pop),
      .item        (item)
   );

   // Back end: walks the table one slot per cycle.
   mhtc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (!item_empty),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_idle   (rsp_idle),
      .rsp_wr     (rsp_wr)
   );

   // Result beats wait here until the step is complete.
   mhtc_rsp u_rsp (
      .clock           (clock),
      .reset           (reset),
      .wr              (rsp_wr),
      .idle            (rsp_idle),
      .empty           (empty),
      .pop             (pop),
      .event_kind      (rsp_event_kind),
      .out_member_id   (rsp_out_member_id),
      .out_member_port (rsp_out_member_port),
      .live_count      (rsp_live_count),
      .last_item       (rsp_last_item)
   );

   // Reset leaves both sides empty.
   `MHTC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, empty && !full, "not empty after reset")
   // Taking the final beat of a step drains the result side.
   `MHTC_ASSERT_NEXT(a_last_drains, clock, reset, !empty && pop && rsp_last_item, empty,
                     "results remain after final beat")
   // Only defined event codes are shown.
   `MHTC_ASSERT_NOW(a_kind_range, clock, reset, !empty,
                    rsp_event_kind <= EV_TICK, "undefined event kind")
   // Live count never exceeds the table size.
   `MHTC_ASSERT_NOW(a_live_range, clock, reset, !empty,
                    rsp_live_count <= LIVE_W'(TABLE_DEPTH), "live count too large")

endmodule

FILE: hdl/mhtc_front.sv
// Input queue that takes items and tags those naming this node itself.
module mhtc_front (
   input  logic              clock,
   input  logic              reset,
   input  mhtc_pkg::cfg_type cfg,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        cmd,
   input  logic [31:0]       member_id,
   input  logic [15:0]       member_port,
   input  logic [31:0]       heartbeat,
   output logic              empty,
   input  logic              pop,
   output mhtc_pkg::item_type item
);
   import mhtc_pkg::*;

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;
   item_type   new_item;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign item    = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.cmd        = cmd_type'(cmd);
      new_item.id         = member_id;
      new_item.port       = member_port;
      new_item.hb         = heartbeat;
      new_item.self_match = (member_id == cfg.self_id) && (member_port == cfg.self_port);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hdl/mhtc_rsp.sv
// Result buffer that holds the beats of one step until its live count is known.
module mhtc_rsp (
   input  logic                      clock,
   input  logic                      reset,
   input  mhtc_pkg::rsp_wr_type      wr,
   output logic                      idle,
   output logic                      empty,
   input  logic                      pop,
   output logic [2:0]                event_kind,
   output logic [31:0]               out_member_id,
   output logic [15:0]               out_member_port,
   output logic [mhtc_pkg::LIVE_W-1:0] live_count,
   output logic                      last_item
);
   import mhtc_pkg::*;

   event_type              kind_ff [RSP_DEPTH];
   logic [31:0]            id_ff   [RSP_DEPTH];
   logic [15:0]            port_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                   done_ff, done_in;
   logic [LIVE_W-1:0]      live_ff;
   logic                   do_pop;

   assign empty           = !done_ff;
   assign idle            = !done_ff && (wr_ptr_ff == '0);
   assign do_pop          = pop && done_ff;
   assign last_item       = (rd_ptr_ff == wr_ptr_ff - RSP_PTR_W'(1));
   assign event_kind      = kind_ff[rd_ptr_ff];
   assign out_member_id   = id_ff[rd_ptr_ff];
   assign out_member_port = port_ff[rd_ptr_ff];
   assign live_count      = live_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      done_in   = done_ff;
      if (wr.push) begin
         wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(1);
      end
      if (wr.finish) begin
         done_in = 1'b1;
      end
      if (do_pop) begin
         if (last_item) begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            done_in   = 1'b0;
         end else begin
            rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         kind_ff[wr_ptr_ff] <= wr.kind;
         id_ff[wr_ptr_ff]   <= wr.id;
         port_ff[wr_ptr_ff] <= wr.port;
      end
      if (wr.finish) begin
         live_ff <= wr.live;
      end
   end

endmodule

FILE: hdl/mhtc_engine.sv
// Table engine: scans, inserts, refreshes and ages entries one slot per cycle.
module mhtc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  mhtc_pkg::cfg_type    cfg,
   input  logic                 item_valid,
   input  mhtc_pkg::item_type   item,
   output logic                 item_pop,
   input  logic                 rsp_idle,
   output mhtc_pkg::rsp_wr_type rsp_wr
);
   import mhtc_pkg::*;

   state_type          state_ff, state_in;
   item_type           cur_ff;
   logic               member_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               found_ff, free_ff;
   logic [IDX_W-1:0]   found_idx_ff, free_idx_ff;
   logic [31:0]        found_hb_ff;
   logic [REM_W-1:0]   removed_ff;
   logic [31:0]        time_ff;
   logic [31:0]        own_hb_ff;
   logic               in_group_ff;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [TABLE_DEPTH-1:0] suspect_ff;
   logic [31:0]        ent_id_ff    [TABLE_DEPTH];
   logic [15:0]        ent_port_ff  [TABLE_DEPTH];
   logic [31:0]        ent_hb_ff    [TABLE_DEPTH];
   logic [31:0]        ent_stamp_ff [TABLE_DEPTH];

   logic        start, scan_last, is_tick, is_match, is_quiet_fail, is_quiet_remove;
   logic        do_remove;
   logic [31:0] quiet;
   event_type   kind;
   logic        do_insert, do_refresh;

   function automatic logic [LIVE_W-1:0] count_live(input logic [TABLE_DEPTH-1:0] v,
                                                    input logic [TABLE_DEPTH-1:0] s);
      logic [LIVE_W:0] n;
      n = '0;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         n = n + {{LIVE_W{1'b0}}, v[k] & ~s[k]};
      end
      return n[LIVE_W-1:0];
   endfunction

   assign is_tick   = (cur_ff.cmd == CMD_TICK);
   assign scan_last = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign start     = (state_ff == ST_IDLE) && item_valid && rsp_idle;
   assign item_pop  = start;
   assign is_match  = valid_ff[idx_ff] && (ent_id_ff[idx_ff] == cur_ff.id)
                      && (ent_port_ff[idx_ff] == cur_ff.port);
   assign quiet           = time_ff - ent_stamp_ff[idx_ff];
   assign is_quiet_fail   = quiet > {16'd0, cfg.fail_to};
   assign is_quiet_remove = quiet > {16'd0, cfg.remove_to};
   assign do_remove = (state_ff == ST_SCAN) && is_tick && valid_ff[idx_ff]
                      && is_quiet_remove && (removed_ff < REM_W'(REMOVE_MAX));

   always_comb begin
      kind       = EV_NONE;
      do_insert  = 1'b0;
      do_refresh = 1'b0;
      if (cur_ff.cmd == CMD_GOSSIP && !member_ff) begin
         kind = EV_NONE;
      end else if (cur_ff.cmd == CMD_GOSSIP && found_ff) begin
         if (cur_ff.hb > found_hb_ff) begin
            kind       = EV_REFRESH;
            do_refresh = 1'b1;
         end
      end else if (cur_ff.self_match || found_ff) begin
         kind = EV_NONE;
      end else if (free_ff) begin
         kind      = EV_ADDED;
         do_insert = 1'b1;
      end else begin
         kind = EV_FULL;
      end
   end

   always_comb begin
      state_in = state_ff;
      rsp_wr   = '0;
      rsp_wr.kind = EV_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (item.cmd == CMD_TICK && !(in_group_ff || cfg.introducer)) begin
                  state_in = ST_DECIDE;
               end else if (item.cmd == CMD_GOSSIP && !(in_group_ff || cfg.introducer)) begin
                  state_in = ST_DECIDE;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (do_remove) begin
               rsp_wr.push = 1'b1;
               rsp_wr.kind = EV_REMOVED;
               rsp_wr.id   = ent_id_ff[idx_ff];
               rsp_wr.port = ent_port_ff[idx_ff];
            end
            if (scan_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rsp_wr.push = 1'b1;
            if (is_tick) begin
               rsp_wr.kind = EV_TICK;
            end else begin
               rsp_wr.kind = kind;
               if (kind != EV_NONE) begin
                  rsp_wr.id   = cur_ff.id;
                  rsp_wr.port = cur_ff.port;
               end
            end
            state_in = ST_FINAL;
         end
         ST_FINAL: begin
            rsp_wr.finish = 1'b1;
            rsp_wr.live   = count_live(valid_ff, suspect_ff);
            state_in      = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff     <= '0;
         own_hb_ff   <= OWN_HB_RESET;
         in_group_ff <= 1'b0;
         valid_ff    <= '0;
         suspect_ff  <= '0;
      end else begin
         if (start) begin
            if (item.cmd == CMD_TICK) begin
               time_ff <= time_ff + 32'd1;
               if (in_group_ff || cfg.introducer) begin
                  own_hb_ff <= own_hb_ff + 32'd1;
               end
            end
            if (item.cmd == CMD_JOIN_REP) begin
               in_group_ff <= 1'b1;
            end
         end
         if (state_ff == ST_SCAN && is_tick && valid_ff[idx_ff]) begin
            if (is_quiet_fail && !do_remove) begin
               suspect_ff[idx_ff] <= 1'b1;
            end
            if (do_remove) begin
               valid_ff[idx_ff]   <= 1'b0;
               suspect_ff[idx_ff] <= 1'b0;
            end
         end
         if (state_ff == ST_DECIDE && !is_tick) begin
            if (do_insert) begin
               valid_ff[free_idx_ff]   <= 1'b1;
               suspect_ff[free_idx_ff] <= 1'b0;
            end
            if (do_refresh) begin
               suspect_ff[found_idx_ff] <= 1'b0;
            end
         end
      end
   end

   // Scan bookkeeping and table payload carry no reset.
   always_ff @(posedge clock) begin
      if (start) begin
         cur_ff     <= item;
         member_ff  <= in_group_ff || cfg.introducer;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         free_ff    <= 1'b0;
         removed_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (is_match && !found_ff) begin
            found_ff     <= 1'b1;
            found_idx_ff <= idx_ff;
            found_hb_ff  <= ent_hb_ff[idx_ff];
         end
         if (!valid_ff[idx_ff] && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
         if (do_remove) begin
            removed_ff <= removed_ff + REM_W'(1);
         end
      end
      if (state_ff == ST_DECIDE && !is_tick) begin
         if (do_insert) begin
            ent_id_ff[free_idx_ff]    <= cur_ff.id;
            ent_port_ff[free_idx_ff]  <= cur_ff.port;
            ent_hb_ff[free_idx_ff]    <= cur_ff.hb;
            ent_stamp_ff[free_idx_ff] <= time_ff;
         end
         if (do_refresh) begin
            ent_hb_ff[found_idx_ff]    <= cur_ff.hb;
            ent_stamp_ff[found_idx_ff] <= time_ff;
         end
      end
   end

endmodule
